// ===== design/adff_pkg.sv =====
// ----------------------------------------------------------------------------
// adff_pkg
// shared types and constants for the adjacent duplicate field filter
// ----------------------------------------------------------------------------
package adff_pkg;

	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 1;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// register indexes
	localparam cfg_idx_t CFG_SEPARATOR = 1'd0;
	localparam cfg_idx_t CFG_LINE_END  = 1'd1;

	localparam byte_t SEPARATOR_RESET = 8'd32;
	localparam byte_t LINE_END_RESET  = 8'd10;

	// sequencer states, one-hot
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_CMP  = 6'b000010,
		S_SEP  = 6'b000100,
		S_RD   = 6'b001000,
		S_WR   = 6'b010000,
		S_EOL  = 6'b100000
	} state_t;

endpackage

// ===== design/adjacent_duplicate_field_filter_core.sv =====
// ----------------------------------------------------------------------------
// adjacent_duplicate_field_filter_core
// drops a field equal to the one before it in the same line and rejoins the
// rest with single separators
// ----------------------------------------------------------------------------
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------
//  in      | in_valid / in_ready     | char_in
//  out     | out_valid / out_ready   | char_out, run_last, token_truncated
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// an ordinary byte first reads the previous field's byte at the same position
// from the token memory, then compares it and writes the byte back.
// a field end reads each emitted byte from memory and then loads it into the
// output register, and loads a separator or line end into the output register.
// reset clears all control state; the token memory itself is not cleared.
// a stalled output holds the sequencer, and no item is accepted until every
// byte caused by the current item is in the output register.
// ----------------------------------------------------------------------------
module adjacent_duplicate_field_filter_core #(
	parameter int MAX_TOKEN = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  adff_pkg::byte_t     char_in,
	output logic                out_valid,
	input  logic                out_ready,
	output adff_pkg::byte_t     char_out,
	output logic                run_last,
	output logic                token_truncated,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  adff_pkg::cfg_idx_t  cfg_index,
	input  adff_pkg::byte_t     cfg_data
);
	import adff_pkg::*;

	localparam int LEN_W  = $clog2(MAX_TOKEN + 1);
	localparam int IDX_W  = (MAX_TOKEN > 1) ? $clog2(MAX_TOKEN) : 1;
	localparam int ADDR_W = IDX_W + 1;
	localparam int DEPTH  = 2 << IDX_W;

	// configuration registers
	byte_t sep_q;
	byte_t eol_q;

	// field bookkeeping
	state_t            state_q;
	logic [LEN_W-1:0]  cur_len_q;
	logic [LEN_W-1:0]  prev_len_q;
	logic              half_q;
	logic              match_q;
	logic              line_out_q;
	logic              ovf_q;
	logic              eol_pend_q;   // field end was caused by a line end
	byte_t             ch_q;
	logic [IDX_W-1:0]  k_q;          // emit position within the field

	// output register
	logic  out_valid_q;
	byte_t char_out_q;
	logic  run_last_q;
	logic  trunc_q;

	// token memory: two halves, current field and previous field
	byte_t             mem [DEPTH];
	byte_t             rd_data_q;
	logic              mem_re;
	logic              mem_we;
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] waddr;

	logic             in_fire;
	logic             is_eol;
	logic             is_sep;
	logic             has_room;
	logic             dup;
	logic             out_free;
	logic             out_load;     // output register takes a new item
	logic [LEN_W-1:0] k_next;
	logic             k_done;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = out_free &&
		((state_q == S_SEP) || (state_q == S_WR) || (state_q == S_EOL));

	assign is_eol   = (char_in == eol_q);
	assign is_sep   = (char_in == sep_q);
	assign has_room = (cur_len_q < LEN_W'(MAX_TOKEN));
	assign dup      = match_q && (prev_len_q != '0) && (cur_len_q == prev_len_q);
	assign k_next   = LEN_W'(k_q) + LEN_W'(1);
	assign k_done   = (k_next == cur_len_q);

	assign out_valid       = out_valid_q;
	assign char_out        = char_out_q;
	assign run_last        = run_last_q;
	assign token_truncated = trunc_q;

	// memory access control
	always_comb begin
		mem_re = 1'b0;
		raddr  = {!half_q, cur_len_q[IDX_W-1:0]};
		mem_we = 1'b0;
		waddr  = {half_q, cur_len_q[IDX_W-1:0]};
		unique case (state_q)
			S_IDLE: begin
				// ordinary byte: fetch previous field's byte at this position
				mem_re = in_fire && !is_eol && !is_sep && has_room;
			end
			S_CMP: begin
				mem_we = 1'b1;
			end
			S_RD: begin
				mem_re = 1'b1;
				raddr  = {half_q, k_q};
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= ch_q;
		end
		if (mem_re) begin
			rd_data_q <= mem[raddr];
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= SEPARATOR_RESET;
			eol_q <= LINE_END_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SEPARATOR: sep_q <= cfg_data;
				CFG_LINE_END:  eol_q <= cfg_data;
				default:       sep_q <= sep_q;
			endcase
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_q <= char_in;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_len_q   <= '0;
			prev_len_q  <= '0;
			half_q      <= 1'b0;
			match_q     <= 1'b1;
			line_out_q  <= 1'b0;
			ovf_q       <= 1'b0;
			eol_pend_q  <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			char_out_q  <= '0;
			run_last_q  <= 1'b0;
			trunc_q     <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						eol_pend_q <= is_eol;
						k_q        <= '0;
						if (is_eol || is_sep) begin
							// line end takes priority over separator
							if (cur_len_q != '0) begin
								if (dup) begin
									// duplicate: becomes previous field, no output
									prev_len_q <= cur_len_q;
									half_q     <= !half_q;
									cur_len_q  <= '0;
									match_q    <= 1'b1;
									ovf_q      <= 1'b0;
									state_q    <= is_eol ? S_EOL : S_IDLE;
								end else if (line_out_q) begin
									state_q <= S_SEP;
								end else begin
									state_q <= S_RD;
								end
							end else if (is_eol) begin
								state_q <= S_EOL;
							end
						end else if (has_room) begin
							state_q <= S_CMP;
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				S_CMP: begin
					// compare with previous field's byte, then store
					if (!(cur_len_q < prev_len_q) || (rd_data_q != ch_q)) begin
						match_q <= 1'b0;
					end
					cur_len_q <= cur_len_q + LEN_W'(1);
					state_q   <= S_IDLE;
				end
				S_SEP: begin
					if (out_free) begin
						char_out_q  <= sep_q;
						run_last_q  <= 1'b0;
						trunc_q     <= 1'b0;
						state_q     <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (out_free) begin
						char_out_q  <= rd_data_q;
						run_last_q  <= k_done && !eol_pend_q;
						trunc_q     <= ovf_q;
						if (k_done) begin
							// field emitted, it becomes the previous field
							prev_len_q <= cur_len_q;
							half_q     <= !half_q;
							cur_len_q  <= '0;
							match_q    <= 1'b1;
							ovf_q      <= 1'b0;
							line_out_q <= 1'b1;
							state_q    <= eol_pend_q ? S_EOL : S_IDLE;
						end else begin
							k_q     <= k_next[IDX_W-1:0];
							state_q <= S_RD;
						end
					end
				end
				S_EOL: begin
					if (out_free) begin
						char_out_q  <= eol_q;
						run_last_q  <= 1'b1;
						trunc_q     <= 1'b0;
						prev_len_q  <= '0;
						line_out_q  <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
